### design/bankers_request_safety_check_top_defines.svh
// ----------------------------------------------------------------------------
// bankers request safety check assertion macros
// concurrent checks on clk, disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef BANKERS_REQUEST_SAFETY_CHECK_TOP_DEFINES_SVH
`define BANKERS_REQUEST_SAFETY_CHECK_TOP_DEFINES_SVH

`ifndef SYNTH
// property that holds on every clock
`define BRSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);
// condition on one clock implies a result on the next
`define BRSC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);
`else
`define BRSC_ASSERT(lbl, prop, msg)
`define BRSC_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

### design/brsc_pkg.sv
// ----------------------------------------------------------------------------
// brsc_pkg
// shared types, codes and defaults of the banker's request safety check
// ----------------------------------------------------------------------------
package brsc_pkg;

  // fixed field widths
  localparam int ACTION_W = 2;
  localparam int PIDX_W   = 4;
  localparam int RIDX_W   = 3;
  localparam int AMOUNT_W = 16;
  localparam int STATUS_W = 2;

  // configuration port
  localparam int PC_W       = 5;
  localparam int RC_W       = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_COUNT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESOURCE_COUNT = 1'd1;

  localparam logic [PC_W-1:0] PROCESS_COUNT_RESET  = 5'd16;
  localparam logic [RC_W-1:0] RESOURCE_COUNT_RESET = 4'd8;

  // parameter defaults
  localparam int DEF_MAX_PROCESSES = 16;
  localparam int DEF_MAX_RESOURCES = 8;
  localparam int DEF_UNIT_WIDTH    = 16;

  // input actions
  localparam logic [ACTION_W-1:0] ACT_ALLOC   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_MAX     = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_AVAIL   = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_REQUEST = 2'd3;

  // decision status
  localparam logic [STATUS_W-1:0] ST_GRANTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EXCEEDS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNAVAIL = 2'd2;
  localparam logic [STATUS_W-1:0] ST_UNSAFE  = 2'd3;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [PIDX_W-1:0]   process_index;
    logic [RIDX_W-1:0]   resource_index;
    logic [AMOUNT_W-1:0] amount;
    logic                last;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PIDX_W-1:0]   process_index_out;
  } result_t;

endpackage

### design/brsc_item_if.sv
// ----------------------------------------------------------------------------
// brsc_item_if
// valid/ready channel carrying load and request items
// ----------------------------------------------------------------------------
interface brsc_item_if import brsc_pkg::*; ();
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/brsc_result_if.sv
// ----------------------------------------------------------------------------
// brsc_result_if
// valid/ready channel carrying decision results
// ----------------------------------------------------------------------------
interface brsc_result_if import brsc_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/bankers_request_safety_check_top.sv
// ----------------------------------------------------------------------------
// bankers_request_safety_check_top
// load, max-claim, available and request elements: one transaction per cycle while idle
// last request element: items.ready low until the decision is in the output
//   register; each element is read from the allocation and need memories,
//   then evaluated
// result held in an output register, loads keep flowing while it waits
// synchronous reset, no clearing pass: tables are undefined until loaded
// ----------------------------------------------------------------------------
`include "bankers_request_safety_check_top_defines.svh"

module bankers_request_safety_check_top import brsc_pkg::*; #(
  parameter int MAX_PROCESSES = DEF_MAX_PROCESSES,
  parameter int MAX_RESOURCES = DEF_MAX_RESOURCES,
  parameter int UNIT_WIDTH    = DEF_UNIT_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  brsc_item_if.sink             items,
  brsc_result_if.source         results
);

  localparam int UW    = UNIT_WIDTH;
  localparam int WW    = UNIT_WIDTH + 4;
  localparam int PIW   = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int RIW   = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int PCW   = $clog2(MAX_PROCESSES + 1);
  localparam int RCW   = $clog2(MAX_RESOURCES + 1);
  localparam int AW    = PIW + RIW;
  localparam int DEPTH = 1 << AW;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CHK_RD  = 4'd1;
  localparam logic [3:0] S_CHK_EV  = 4'd2;
  localparam logic [3:0] S_GR_RD   = 4'd3;
  localparam logic [3:0] S_GR_WR   = 4'd4;
  localparam logic [3:0] S_SCAN    = 4'd5;
  localparam logic [3:0] S_FIT_RD  = 4'd6;
  localparam logic [3:0] S_FIT_EV  = 4'd7;
  localparam logic [3:0] S_ADD_RD  = 4'd8;
  localparam logic [3:0] S_ADD_EV  = 4'd9;
  localparam logic [3:0] S_UNDO_RD = 4'd10;
  localparam logic [3:0] S_UNDO_WR = 4'd11;
  localparam logic [3:0] S_DONE    = 4'd12;

  // configuration
  logic [PC_W-1:0] process_count;
  logic [RC_W-1:0] resource_count;
  logic [PCW-1:0]  np;
  logic [RCW-1:0]  nr;

  // control
  logic [3:0]        state;
  logic [PIDX_W-1:0] pr;
  logic [STATUS_W-1:0] status;
  logic [RCW-1:0]    jr;
  logic [PCW-1:0]    ip;
  logic [PCW-1:0]    done_cnt;
  logic [MAX_PROCESSES-1:0] fin;

  // small vectors
  logic [UW-1:0] avail   [MAX_RESOURCES];
  logic [UW-1:0] req_buf [MAX_RESOURCES];
  logic [WW-1:0] work    [MAX_RESOURCES];

  // table memories
  logic [UW-1:0] alloc_mem [DEPTH];
  logic [UW:0]   need_mem  [DEPTH];
  logic [UW-1:0] alloc_q;
  logic [UW:0]   need_q;

  logic          alloc_we;
  logic [AW-1:0] alloc_waddr;
  logic [UW-1:0] alloc_wdata;
  logic          need_we;
  logic [AW-1:0] need_waddr;
  logic [UW:0]   need_wdata;
  logic [AW-1:0] raddr;

  // pending need write of a max-claim load
  logic          pend_valid;
  logic [AW-1:0] pend_addr;
  logic [UW-1:0] pend_amt;

  // output register
  logic    out_valid;
  result_t out_data;

  logic          item_acc;
  logic          slot_free;
  logic          r_ok;
  logic          p_ok;
  logic [RIW-1:0] in_ri;
  logic [AW-1:0] in_addr;
  logic [UW-1:0] in_amt;
  logic [RIW-1:0] jj;
  logic [PIW-1:0] cur_pi;
  logic [AW-1:0] tab_addr;
  logic [UW-1:0] rq;
  logic          fail_need;
  logic          fail_avail;
  logic          fail_fit;
  logic [WW:0]   work_sum;
  logic          req_nonzero;

  assign np = (process_count > MAX_PROCESSES) ? PCW'(MAX_PROCESSES) : PCW'(process_count);
  assign nr = (resource_count > MAX_RESOURCES) ? RCW'(MAX_RESOURCES) : RCW'(resource_count);

  assign items.ready   = (state == S_IDLE);
  assign item_acc      = items.valid && items.ready;
  assign results.valid = out_valid;
  assign results.data  = out_data;
  assign slot_free     = !out_valid || results.ready;

  assign r_ok    = ({1'b0, items.data.resource_index} < (RIDX_W + 1)'(nr));
  assign p_ok    = ({1'b0, items.data.process_index} < (PIDX_W + 1)'(np));
  assign in_ri   = RIW'(items.data.resource_index);
  assign in_addr = {PIW'(items.data.process_index), in_ri};
  assign in_amt  = UW'(items.data.amount);

  assign jj       = jr[RIW-1:0];
  assign cur_pi   = (state == S_FIT_RD || state == S_FIT_EV ||
                     state == S_ADD_RD || state == S_ADD_EV) ? ip[PIW-1:0] : PIW'(pr);
  assign tab_addr = {cur_pi, jj};
  assign raddr    = (state == S_IDLE) ? in_addr : tab_addr;
  assign rq       = req_buf[jj];

  // need check treats negative need as zero room, available check is plain
  assign fail_need  = (rq != '0) && (need_q[UW] || (rq > need_q[UW-1:0]));
  assign fail_avail = (rq > avail[jj]);
  // in the safety search a negative need always fits
  assign fail_fit   = !need_q[UW] && (WW'(need_q[UW-1:0]) > work[jj]);
  assign work_sum   = {1'b0, work[jj]} + (WW + 1)'(alloc_q);

  always_comb begin
    req_nonzero = 1'b0;
    for (int k = 0; k < MAX_RESOURCES; k++) begin
      req_nonzero = req_nonzero | (req_buf[k] != '0);
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      process_count  <= PROCESS_COUNT_RESET;
      resource_count <= RESOURCE_COUNT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PROCESS_COUNT:  process_count  <= cfg_data[PC_W-1:0];
        REG_RESOURCE_COUNT: resource_count <= cfg_data[RC_W-1:0];
        default: ;
      endcase
    end
  end

  // memory write port selection
  always_comb begin
    alloc_we    = 1'b0;
    alloc_waddr = tab_addr;
    alloc_wdata = alloc_q;
    need_we     = 1'b0;
    need_waddr  = tab_addr;
    need_wdata  = need_q;
    if (item_acc && items.data.action == ACT_ALLOC && r_ok && p_ok) begin
      alloc_we    = 1'b1;
      alloc_waddr = in_addr;
      alloc_wdata = in_amt;
    end
    if (state == S_GR_WR) begin
      alloc_we    = 1'b1;
      alloc_wdata = alloc_q + rq;
      need_we     = 1'b1;
      need_wdata  = need_q - {1'b0, rq};
    end
    if (state == S_UNDO_WR) begin
      alloc_we    = 1'b1;
      alloc_wdata = alloc_q - rq;
      need_we     = 1'b1;
      need_wdata  = need_q + {1'b0, rq};
    end
    if (pend_valid) begin
      need_we    = 1'b1;
      need_waddr = pend_addr;
      need_wdata = {1'b0, pend_amt} - {1'b0, alloc_q};
    end
  end

  always_ff @(posedge clk) begin
    if (alloc_we) begin
      alloc_mem[alloc_waddr] <= alloc_wdata;
    end
    alloc_q <= alloc_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (need_we) begin
      need_mem[need_waddr] <= need_wdata;
    end
    need_q <= need_mem[raddr];
  end

  // pending need write of max-claim loads
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else begin
      pend_valid <= item_acc && items.data.action == ACT_MAX && r_ok && p_ok;
    end
    pend_addr <= in_addr;
    pend_amt  <= in_amt;
  end

  // decision sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      fin       <= '0;
      req_buf   <= '{default: '0};
      work      <= '{default: '0};
    end else begin
      // the final state reloads the output register itself
      if (out_valid && results.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_acc) begin
            case (items.data.action)
              ACT_REQUEST: begin
                if (r_ok) begin
                  req_buf[in_ri] <= in_amt;
                end
                if (items.data.last) begin
                  pr <= items.data.process_index;
                  jr <= '0;
                  if (p_ok) begin
                    state <= S_CHK_RD;
                  end else begin
                    status <= ST_EXCEEDS;
                    state  <= S_DONE;
                  end
                end
              end
              ACT_AVAIL: begin
                if (r_ok) begin
                  avail[in_ri] <= in_amt;
                end
              end
              default: ;
            endcase
          end
        end
        S_CHK_RD: begin
          if (jr == nr) begin
            jr    <= '0;
            state <= S_GR_RD;
          end else begin
            state <= S_CHK_EV;
          end
        end
        S_CHK_EV: begin
          if (fail_need) begin
            status <= ST_EXCEEDS;
            state  <= S_DONE;
          end else if (fail_avail) begin
            status <= ST_UNAVAIL;
            state  <= S_DONE;
          end else begin
            jr    <= jr + RCW'(1);
            state <= S_CHK_RD;
          end
        end
        S_GR_RD: begin
          if (jr == nr) begin
            for (int k = 0; k < MAX_RESOURCES; k++) begin
              work[k] <= WW'(avail[k]);
            end
            fin      <= '0;
            done_cnt <= '0;
            ip       <= '0;
            state    <= S_SCAN;
          end else begin
            state <= S_GR_WR;
          end
        end
        S_GR_WR: begin
          avail[jj] <= avail[jj] - rq;
          jr        <= jr + RCW'(1);
          state     <= S_GR_RD;
        end
        S_SCAN: begin
          jr <= '0;
          if (done_cnt == np) begin
            status <= ST_GRANTED;
            state  <= S_DONE;
          end else if (ip == np) begin
            state <= S_UNDO_RD;
          end else if (fin[ip[PIW-1:0]]) begin
            ip <= ip + PCW'(1);
          end else begin
            state <= S_FIT_RD;
          end
        end
        S_FIT_RD: begin
          if (jr == nr) begin
            jr    <= '0;
            state <= S_ADD_RD;
          end else begin
            state <= S_FIT_EV;
          end
        end
        S_FIT_EV: begin
          if (fail_fit) begin
            ip    <= ip + PCW'(1);
            state <= S_SCAN;
          end else begin
            jr    <= jr + RCW'(1);
            state <= S_FIT_RD;
          end
        end
        S_ADD_RD: begin
          if (jr == nr) begin
            fin[ip[PIW-1:0]] <= 1'b1;
            done_cnt         <= done_cnt + PCW'(1);
            ip               <= '0;
            state            <= S_SCAN;
          end else begin
            state <= S_ADD_EV;
          end
        end
        S_ADD_EV: begin
          // work saturates at all ones
          work[jj] <= work_sum[WW] ? '1 : work_sum[WW-1:0];
          jr       <= jr + RCW'(1);
          state    <= S_ADD_RD;
        end
        S_UNDO_RD: begin
          if (jr == nr) begin
            status <= ST_UNSAFE;
            state  <= S_DONE;
          end else begin
            state <= S_UNDO_WR;
          end
        end
        S_UNDO_WR: begin
          avail[jj] <= avail[jj] + rq;
          jr        <= jr + RCW'(1);
          state     <= S_UNDO_RD;
        end
        S_DONE: begin
          if (slot_free) begin
            out_valid                  <= 1'b1;
            out_data.status            <= status;
            out_data.process_index_out <= pr;
            req_buf                    <= '{default: '0};
            state                      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a result only ever comes out of the decision's final state
  `BRSC_ASSERT(a_result_from_done, $rose(out_valid) |-> $past(state) == S_DONE, "stray result")
  // the need write of a max-claim load lands while idle, clear of grant and undo writes
  `BRSC_ASSERT(a_need_port_free, pend_valid |-> state == S_IDLE, "need port clash")
  // the request buffer is empty once a decision has been handed out
  `BRSC_ASSERT_NEXT(a_req_cleared, state == S_DONE && slot_free, !req_nonzero, "stale request")

endmodule

### tb/tb_bankers_request_safety_check_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bankers_request_safety_check_top
// loads allocation, max-claim and available tables, then streams request
// transactions and checks every decision against a banker's algorithm
// predictor kept in the testbench, over several process/resource counts
// ----------------------------------------------------------------------------
module tb_bankers_request_safety_check_top;
  import brsc_pkg::*;

  localparam int MAX_P         = DEF_MAX_PROCESSES;
  localparam int MAX_R         = DEF_MAX_RESOURCES;
  localparam int UNIT_MAX      = (1 << DEF_UNIT_WIDTH) - 1;
  localparam int WORK_CAP      = (1 << (DEF_UNIT_WIDTH + 4)) - 1;
  localparam int ITEM_TARGET   = 1650;
  localparam int SETTLE_CYCLES = 32;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  brsc_item_if   item_ch ();
  brsc_result_if result_ch ();

  bankers_request_safety_check_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .items     (item_ch),
    .results   (result_ch)
  );

  // predictor state
  logic [PC_W-1:0]            proc_count_cfg;
  logic [RC_W-1:0]            res_count_cfg;
  logic [AMOUNT_W-1:0]        held_units [MAX_P][MAX_R];
  logic signed [AMOUNT_W:0]   claim_gap [MAX_P][MAX_R];
  logic [AMOUNT_W-1:0]        free_units [MAX_R];
  logic [AMOUNT_W-1:0]        staged_units [MAX_R];
  result_t                    pending_decisions [$];

  item_t   feed_q [$];
  result_t want;
  int      pushed_count;
  int      noise_count;
  int      accepted_count;
  int      mismatch_count;
  int      item_gap_pct;
  int      result_stall_pct;
  int      gap_left;
  int      stall_left;

  always #10 clk = ~clk;

  // safety search: repeatedly finish the lowest unfinished process that fits
  function automatic bit state_is_safe(input int np, input int nr);
    logic [19:0] spare [MAX_R];
    bit          done_flag [MAX_P];
    int          pass, i, j, gap, sum;
    bit          found, fits;
    for (j = 0; j < nr; j++) spare[j] = free_units[j];
    for (i = 0; i < MAX_P; i++) done_flag[i] = 1'b0;
    for (pass = 0; pass < np; pass++) begin
      found = 1'b0;
      for (i = 0; i < np && !found; i++) begin
        if (!done_flag[i]) begin
          fits = 1'b1;
          for (j = 0; j < nr; j++) begin
            gap = claim_gap[i][j];
            if (gap > 0 && gap > int'(spare[j])) fits = 1'b0;
          end
          if (fits) begin
            for (j = 0; j < nr; j++) begin
              sum = int'(spare[j]) + int'(held_units[i][j]);
              spare[j] = (sum > WORK_CAP) ? 20'(WORK_CAP) : 20'(sum);
            end
            done_flag[i] = 1'b1;
            found = 1'b1;
          end
        end
      end
      if (!found) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [STATUS_W-1:0] judge_request(input int p, input int np,
                                                        input int nr);
    int j, gap, ask;
    if (p >= np) return ST_EXCEEDS;
    for (j = 0; j < nr; j++) begin
      gap = claim_gap[p][j];
      ask = staged_units[j];
      if (gap < 0 ? ask > 0 : ask > gap) return ST_EXCEEDS;
      if (ask > int'(free_units[j])) return ST_UNAVAIL;
    end
    // tentative grant, allocation wraps at the unit width
    for (j = 0; j < nr; j++) begin
      free_units[j]    = free_units[j] - staged_units[j];
      held_units[p][j] = held_units[p][j] + staged_units[j];
      claim_gap[p][j]  = (AMOUNT_W+1)'(int'(claim_gap[p][j]) - int'(staged_units[j]));
    end
    if (state_is_safe(np, nr)) return ST_GRANTED;
    for (j = 0; j < nr; j++) begin
      free_units[j]    = free_units[j] + staged_units[j];
      held_units[p][j] = held_units[p][j] - staged_units[j];
      claim_gap[p][j]  = (AMOUNT_W+1)'(int'(claim_gap[p][j]) + int'(staged_units[j]));
    end
    return ST_UNSAFE;
  endfunction

  function automatic void book_item(input item_t it);
    int      np, nr, p, r;
    bit      r_ok, p_ok;
    result_t verdict;
    np = (proc_count_cfg > MAX_P) ? MAX_P : int'(proc_count_cfg);
    nr = (res_count_cfg > MAX_R) ? MAX_R : int'(res_count_cfg);
    p = it.process_index;
    r = it.resource_index;
    r_ok = r < nr;
    p_ok = p < np;
    case (it.action)
      ACT_REQUEST: begin
        if (r_ok) staged_units[r] = it.amount;
        if (it.last) begin
          verdict.status = judge_request(p, np, nr);
          verdict.process_index_out = it.process_index;
          pending_decisions.push_back(verdict);
          foreach (staged_units[k]) staged_units[k] = '0;
        end
      end
      ACT_AVAIL: begin
        if (r_ok) free_units[r] = it.amount;
      end
      ACT_ALLOC: begin
        if (r_ok && p_ok) held_units[p][r] = it.amount;
      end
      ACT_MAX: begin
        if (r_ok && p_ok)
          claim_gap[p][r] = (AMOUNT_W+1)'(int'(it.amount) - int'(held_units[p][r]));
      end
    endcase
  endfunction

  task automatic push_item(input logic [ACTION_W-1:0] act, input int p, input int r,
                           input int amt, input bit fin);
    item_t it;
    it.action         = act;
    it.process_index  = PIDX_W'(p);
    it.resource_index = RIDX_W'(r);
    it.amount         = AMOUNT_W'(amt);
    it.last           = fin;
    feed_q.push_back(it);
    pushed_count++;
  endtask

  task automatic push_noise();
    int amt;
    amt = $urandom_range(0, 1) ? $urandom_range(0, UNIT_MAX) : $urandom_range(0, 7);
    push_item(ACTION_W'($urandom_range(0, 3)), $urandom_range(0, 15),
              $urandom_range(0, 7), amt, $urandom_range(0, 1));
    noise_count++;
  endtask

  // small random reload of one cell in use
  task automatic push_churn(input int np, input int nr);
    logic [ACTION_W-1:0] load_kinds [3];
    logic [ACTION_W-1:0] kind;
    int                  amt;
    load_kinds = '{ACT_ALLOC, ACT_MAX, ACT_AVAIL};
    kind = load_kinds[$urandom_range(0, 2)];
    if (kind == ACT_ALLOC) amt = $urandom_range(0, 3);
    else if (kind == ACT_MAX) amt = $urandom_range(0, 6);
    else amt = $urandom_range(0, 8);
    push_item(kind, (np > 0) ? $urandom_range(0, np - 1) : 0,
              (nr > 0) ? $urandom_range(0, nr - 1) : 0, amt, 1'b0);
  endtask

  task automatic seed_tables(input int np, input int nr, input bit big);
    int i, j, held, claim;
    for (i = 0; i < np; i++) begin
      for (j = 0; j < nr; j++) begin
        held = big ? $urandom_range(60000, UNIT_MAX) : $urandom_range(0, 3);
        claim = held + $urandom_range(0, 3);
        if (claim > UNIT_MAX) claim = UNIT_MAX;
        push_item(ACT_ALLOC, i, j, held, 1'b0);
        push_item(ACT_MAX, i, j, claim, 1'b0);
      end
    end
    for (j = 0; j < nr; j++)
      push_item(ACT_AVAIL, 0, j, big ? $urandom_range(60000, UNIT_MAX) : $urandom_range(1, 8),
                1'b0);
  endtask

  // one request: elements for a random subset of resources, then the last one
  task automatic push_request(input int np, input int nr);
    int p, j;
    if (np == 0 || $urandom_range(0, 9) == 0) p = $urandom_range(0, 15);
    else p = $urandom_range(0, np - 1);
    for (j = 0; j < MAX_R; j++) begin
      if ((j < nr && $urandom_range(0, 2) != 0) || (j >= nr && $urandom_range(0, 19) == 0))
        push_item(ACT_REQUEST, p, j, $urandom_range(0, 3), 1'b0);
    end
    push_item(ACT_REQUEST, p, $urandom_range(0, 7), $urandom_range(0, 3), 1'b1);
  endtask

  task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_PROCESS_COUNT) proc_count_cfg = PC_W'(val);
    else res_count_cfg = RC_W'(val);
  endtask

  task automatic await_quiet();
    while (accepted_count != pushed_count || pending_decisions.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // transaction driver
  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else if (!item_ch.valid || item_ch.ready) begin
      if (gap_left > 0) begin
        item_ch.valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (feed_q.size() > 0) begin
        item_ch.data  <= feed_q.pop_front();
        item_ch.valid <= 1'b1;
        if ($urandom_range(0, 99) < item_gap_pct) gap_left <= $urandom_range(1, 5);
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      result_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      result_ch.ready <= 1'b1;
      if ($urandom_range(0, 99) < result_stall_pct) stall_left <= $urandom_range(1, 5);
    end
  end

  // monitor: check decisions, predict from accepted transactions
  always @(posedge clk) begin
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) begin
        if (pending_decisions.size() == 0) begin
          $display("%0t: unexpected decision, expected none, actual status %0d process %0d",
                   $time, result_ch.data.status, result_ch.data.process_index_out);
          mismatch_count++;
        end else begin
          want = pending_decisions.pop_front();
          if (result_ch.data.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d (process %0d)",
                     $time, want.status, result_ch.data.status, want.process_index_out);
            mismatch_count++;
          end
          if (result_ch.data.process_index_out !== want.process_index_out) begin
            $display("%0t: process mismatch, expected %0d, actual %0d",
                     $time, want.process_index_out, result_ch.data.process_index_out);
            mismatch_count++;
          end
        end
      end
      if (item_ch.valid && item_ch.ready) begin
        book_item(item_ch.data);
        accepted_count++;
      end
    end
  end

  initial begin
    int plan_pc [$];
    int plan_rc [$];
    int i, j, pc, rc, np, nr, phase, n_req, roll;
    bit quiet;
    clk = 1'b0;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    item_ch.valid = 1'b0;
    item_ch.data = '0;
    result_ch.ready = 1'b0;
    pushed_count = 0;
    noise_count = 0;
    accepted_count = 0;
    mismatch_count = 0;
    gap_left = 0;
    stall_left = 0;
    item_gap_pct = 20;
    result_stall_pct = 20;
    proc_count_cfg = PROCESS_COUNT_RESET;
    res_count_cfg = RESOURCE_COUNT_RESET;
    foreach (staged_units[k]) staged_units[k] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // full tables at reset counts: allocation 1, need 2, available 4
    for (i = 0; i < MAX_P; i++) begin
      for (j = 0; j < MAX_R; j++) begin
        push_item(ACT_ALLOC, i, j, 1, 1'b0);
        push_item(ACT_MAX, i, j, 3, 1'b0);
      end
    end
    for (j = 0; j < MAX_R; j++) push_item(ACT_AVAIL, 0, j, 4, 1'b0);

    // two-element request, granted
    push_item(ACT_REQUEST, 2, 0, 1, 1'b0);
    push_item(ACT_REQUEST, 2, 7, 2, 1'b1);
    // more than the claim
    push_item(ACT_REQUEST, 3, 1, 3, 1'b1);
    // not available; last flag on a load is ignored
    push_item(ACT_AVAIL, 0, 4, 1, 1'b1);
    push_item(ACT_REQUEST, 4, 4, 2, 1'b1);
    // grant leaves nobody able to finish, rolled back
    push_item(ACT_REQUEST, 6, 4, 1, 1'b1);
    push_item(ACT_AVAIL, 0, 4, 4, 1'b0);
    // buffered element counts, then the buffer is empty again
    push_item(ACT_REQUEST, 1, 3, 2, 1'b0);
    push_item(ACT_REQUEST, 1, 0, 0, 1'b1);
    push_item(ACT_REQUEST, 1, 0, 0, 1'b1);
    // allocation above max claim gives negative need
    push_item(ACT_ALLOC, 7, 2, 10, 1'b1);
    push_item(ACT_MAX, 7, 2, 5, 1'b0);
    push_item(ACT_REQUEST, 7, 2, 1, 1'b1);
    push_item(ACT_REQUEST, 7, 0, 0, 1'b1);
    // allocation wraps on the tentative grant and is restored on undo
    push_item(ACT_ALLOC, 8, 1, 0, 1'b0);
    push_item(ACT_MAX, 8, 1, UNIT_MAX, 1'b0);
    push_item(ACT_ALLOC, 8, 1, UNIT_MAX, 1'b0);
    push_item(ACT_REQUEST, 8, 1, 3, 1'b1);
    push_item(ACT_MAX, 8, 1, UNIT_MAX, 1'b0);
    push_item(ACT_REQUEST, 15, 6, 2, 1'b1);
    push_item(ACT_REQUEST, 0, 5, 65535, 1'b1);

    // count settings: zero, one, full and above the maximum come first
    plan_pc = '{1, 0, 4, 31, 2, 16, 5, 3};
    plan_rc = '{1, 3, 0, 15, 8, 1, 3, 2};
    phase = 0;
    while (pushed_count - noise_count < ITEM_TARGET) begin
      if (phase < plan_pc.size()) begin
        pc = plan_pc[phase];
        rc = plan_rc[phase];
      end else if ($urandom_range(0, 9) == 0) begin
        pc = $urandom_range(0, 31);
        rc = $urandom_range(0, 15);
      end else begin
        pc = $urandom_range(1, 6);
        rc = $urandom_range(1, 4);
      end
      await_quiet();
      quiet = (ITEM_TARGET - (pushed_count - noise_count)) < 300;
      item_gap_pct = quiet ? 0 : 20 * $urandom_range(0, 2);
      result_stall_pct = quiet ? 0 : 20 * $urandom_range(0, 2);
      set_register(REG_PROCESS_COUNT, pc);
      set_register(REG_RESOURCE_COUNT, rc);
      np = (pc > MAX_P) ? MAX_P : pc;
      nr = (rc > MAX_R) ? MAX_R : rc;
      // large units only when the process count is set to 31, drives work to saturation
      seed_tables(np, nr, pc == 31);
      // full-size searches are slow, keep their request count low
      n_req = (np * np * nr > 128) ? 12 : 40;
      repeat (n_req) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) push_noise();
        else if (roll < 16) push_churn(np, nr);
        else push_request(np, nr);
      end
      phase++;
    end

    await_quiet();
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #50000000;
    $display("FAIL");
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/brsc_pkg.sv
design/brsc_item_if.sv
design/brsc_result_if.sv
design/bankers_request_safety_check_top.sv
tb/tb_bankers_request_safety_check_top.sv
